// ===== rtl/pose_frame_transform_macros.svh =====
// Assertion helpers for the pose frame transform.
// Both macros expect clk and rst_n in scope.
`ifndef POSE_FRAME_TRANSFORM_MACROS_SVH
`define POSE_FRAME_TRANSFORM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset
`define PFT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next
`define PFT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFT_ASSERT(name, prop, msg)
`define PFT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/pft_pkg.sv =====
package pft_pkg;

    // Configuration register indexes
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_CENTER_X    = 2'd0;
    localparam reg_index_t REG_CENTER_Y    = 2'd1;
    localparam reg_index_t REG_FRAME_ANGLE = 2'd2;

    // Request kinds carried in tuser
    localparam logic ACT_TO_LOCAL = 1'b0;
    localparam logic ACT_TO_WORLD = 1'b1;

    // CORDIC constants: angles in 2^32 codes per turn, values in Q2.30
    localparam int TABLE_LEN = 24;
    localparam logic signed [33:0] Q30_INV_GAIN = 34'sd652032874;
    localparam logic signed [17:0] COS_ONE      = 18'sd65536;
    localparam logic [30:0] ATAN_TURN32 [TABLE_LEN] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81
    };

    // Q2.30 to Q1.16, round half up, clamped to +-1.0
    function automatic logic signed [17:0] round_q16(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [20:0] r;
        logic signed [17:0] res;
        t = 35'(v) + 35'sd8192;
        r = 21'(t >>> 14);
        if (r > 21'sd65536)
            res = 18'sd65536;
        else if (r < -21'sd65536)
            res = -18'sd65536;
        else
            res = 18'(r);
        return res;
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] res;
        if (v > 37'sd2147483647)
            res = 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            res = 32'sh80000000;
        else
            res = 32'(v);
        return res;
    endfunction

    // Pipeline stage payloads
    typedef struct packed {
        logic               act;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [16:0] hsum;
    } stage1_t;

    typedef struct packed {
        logic               act;
        logic signed [50:0] ac;
        logic signed [50:0] bs;
        logic signed [50:0] bc;
        logic signed [50:0] as_p;
        logic signed [16:0] heading;
    } stage2_t;

    typedef struct packed {
        logic               act;
        logic signed [35:0] rx;
        logic signed [35:0] ry;
        logic signed [16:0] heading;
    } stage3_t;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [16:0] heading;
    } stage4_t;

endpackage

// ===== rtl/pose_frame_transform.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: in_x, in_y, in_heading; tuser: action
// m_*       out  m_tvalid/m_tready  tdata: out_x, out_y, out_heading
// cfg_*     in   cfg_write          cfg_index, cfg_data
//
// Four register stages: difference, multiply, sum and round, offset and saturate.
// One request per cycle while s_tready is high; m_tvalid rises when stage 4 loads the request.
// A frame_angle write runs an iterative CORDIC of CORDIC_STEPS micro-rotations
// (capped at TABLE_LEN) and a final rounding step; s_tready stays low over that time.
// Reset leaves cosine at 1.0, sine at 0, and the centers, frame angle and valid bits at 0.
// Stalls on the output freeze each full stage; an empty stage still fills.
`include "pose_frame_transform_macros.svh"

module pose_frame_transform
    import pft_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // in_x[31:0], in_y[63:32], in_heading[79:64]
    input  logic        s_tuser,   // action[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // out_x[31:0], out_y[63:32], out_heading[80:64], zero
);

    localparam int NSTEPS  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W  = $clog2(NSTEPS + 1);
    localparam int IDX_W   = $clog2(TABLE_LEN);
    localparam int HEXT_W  = (ANGLE_BITS >= 17) ? ANGLE_BITS + 1 : 18;
    localparam logic [HEXT_W-1:0] TURN = HEXT_W'(1) << ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;

    // configuration and rotation state
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [15:0] frame_angle_reg;
    logic signed [17:0] cos_reg;
    logic signed [17:0] sin_reg;

    // CORDIC sequencer
    logic               busy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic signed [33:0] cordic_x_reg, cordic_x_next;
    logic signed [33:0] cordic_y_reg, cordic_y_next;
    logic signed [33:0] cordic_z_reg, cordic_z_next;

    // pipeline
    logic    v1_reg, v2_reg, v3_reg, v4_reg;
    logic    en1, en2, en3, en4;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    stage3_t s3_reg, s3_next;
    stage4_t s4_reg, s4_next;

    logic angle_write;
    assign angle_write = cfg_write && (cfg_index == REG_FRAME_ANGLE);

    // CORDIC load and one micro-rotation per cycle
    logic signed [31:0] fa32;
    logic signed [31:0] z_raw;
    logic signed [33:0] z_fold;
    logic               fold_neg;
    logic signed [33:0] xs, ys, atan_step;
    logic [IDX_W-1:0]   atan_idx;
    logic signed [33:0] fin_x, fin_y;

    always_comb
    begin
        fa32     = 32'(signed'(cfg_data[15:0]));
        z_raw    = fa32 <<< ANGLE_SHIFT;
        z_fold   = 34'(z_raw);
        fold_neg = 1'b0;
        if (z_raw > 32'sd1073741824)
        begin
            z_fold   = 34'(z_raw) - 34'sd2147483648;
            fold_neg = 1'b1;
        end
        else if (z_raw < -32'sd1073741824)
        begin
            z_fold   = 34'(z_raw) + 34'sd2147483648;
            fold_neg = 1'b1;
        end

        atan_idx  = IDX_W'(step_reg);
        atan_step = 34'(ATAN_TURN32[atan_idx]);
        xs        = cordic_x_reg >>> step_reg;
        ys        = cordic_y_reg >>> step_reg;
        if (!cordic_z_reg[33])
        begin
            cordic_x_next = cordic_x_reg - ys;
            cordic_y_next = cordic_y_reg + xs;
            cordic_z_next = cordic_z_reg - atan_step;
        end
        else
        begin
            cordic_x_next = cordic_x_reg + ys;
            cordic_y_next = cordic_y_reg - xs;
            cordic_z_next = cordic_z_reg + atan_step;
        end

        fin_x = neg_reg ? -cordic_x_reg : cordic_x_reg;
        fin_y = neg_reg ? -cordic_y_reg : cordic_y_reg;
    end

    // control: config registers, rotation state, sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            frame_angle_reg <= '0;
            cos_reg         <= COS_ONE;
            sin_reg         <= '0;
            busy_reg        <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CENTER_X:    center_x_reg <= cfg_data;
                    REG_CENTER_Y:    center_y_reg <= cfg_data;
                    REG_FRAME_ANGLE: frame_angle_reg <= cfg_data[15:0];
                    default:         ;
                endcase
            end
            if (angle_write)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(NSTEPS))
                begin
                    cos_reg  <= round_q16(fin_x);
                    sin_reg  <= round_q16(fin_y);
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    // CORDIC datapath
    always_ff @(posedge clk)
    begin
        if (angle_write)
        begin
            cordic_x_reg <= Q30_INV_GAIN;
            cordic_y_reg <= '0;
            cordic_z_reg <= z_fold;
            neg_reg      <= fold_neg;
        end
        else if (busy_reg && (step_reg != STEP_W'(NSTEPS)))
        begin
            cordic_x_reg <= cordic_x_next;
            cordic_y_reg <= cordic_y_next;
            cordic_z_reg <= cordic_z_next;
        end
    end

    // stage enables: a stage loads when empty or when it moves on
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1 && !busy_reg;

    // stage 1: offsets from the center when going to local, heading sum or difference
    logic signed [31:0] in_x, in_y;
    logic signed [15:0] in_heading;

    always_comb
    begin
        in_x       = s_tdata[31:0];
        in_y       = s_tdata[63:32];
        in_heading = s_tdata[79:64];
        s1_next.act = s_tuser;
        if (s_tuser == ACT_TO_LOCAL)
        begin
            s1_next.a    = 33'(in_x) - 33'(center_x_reg);
            s1_next.b    = 33'(in_y) - 33'(center_y_reg);
            s1_next.hsum = 17'(in_heading) - 17'(frame_angle_reg);
        end
        else
        begin
            s1_next.a    = 33'(in_x);
            s1_next.b    = 33'(in_y);
            s1_next.hsum = 17'(in_heading) + 17'(frame_angle_reg);
        end
    end

    // stage 2: four products, heading wrap
    logic signed [HEXT_W-1:0] h_ext;
    logic [ANGLE_BITS-1:0]    h_mod;
    logic [HEXT_W-1:0]        h_wrap;

    always_comb
    begin
        h_ext  = HEXT_W'(s1_reg.hsum);
        h_mod  = h_ext[ANGLE_BITS-1:0];
        h_wrap = HEXT_W'(h_mod);
        if (h_mod > HALF)
            h_wrap = HEXT_W'(h_mod) - TURN;
        s2_next.act     = s1_reg.act;
        s2_next.ac      = 51'(s1_reg.a) * 51'(cos_reg);
        s2_next.bs      = 51'(s1_reg.b) * 51'(sin_reg);
        s2_next.bc      = 51'(s1_reg.b) * 51'(cos_reg);
        s2_next.as_p    = 51'(s1_reg.a) * 51'(sin_reg);
        s2_next.heading = h_wrap[16:0];
    end

    // stage 3: sum products, round half up, dropping the 16 fraction bits of Q1.16
    logic signed [51:0] sum_x, sum_y;

    always_comb
    begin
        if (s2_reg.act == ACT_TO_LOCAL)
        begin
            sum_x = 52'(s2_reg.ac) + 52'(s2_reg.bs) + 52'sd32768;
            sum_y = 52'(s2_reg.bc) - 52'(s2_reg.as_p) + 52'sd32768;
        end
        else
        begin
            sum_x = 52'(s2_reg.ac) - 52'(s2_reg.bs) + 52'sd32768;
            sum_y = 52'(s2_reg.as_p) + 52'(s2_reg.bc) + 52'sd32768;
        end
        s3_next.act     = s2_reg.act;
        s3_next.rx      = 36'(sum_x >>> 16);
        s3_next.ry      = 36'(sum_y >>> 16);
        s3_next.heading = s2_reg.heading;
    end

    // stage 4: add center on the way back to world, saturate
    logic signed [36:0] off_x, off_y;

    always_comb
    begin
        off_x = 37'(s3_reg.rx);
        off_y = 37'(s3_reg.ry);
        if (s3_reg.act == ACT_TO_WORLD)
        begin
            off_x = 37'(s3_reg.rx) + 37'(center_x_reg);
            off_y = 37'(s3_reg.ry) + 37'(center_y_reg);
        end
        s4_next.ox      = sat32(off_x);
        s4_next.oy      = sat32(off_y);
        s4_next.heading = s3_reg.heading;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid && !busy_reg;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
        if (en4)
            s4_reg <= s4_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'd0, s4_reg.heading, s4_reg.oy, s4_reg.ox};

    // checks
    `PFT_ASSERT_NEXT(a_angle_starts_cordic, angle_write, busy_reg && !s_tready, "angle write did not start CORDIC")
    `PFT_ASSERT(a_step_bound, !busy_reg || (step_reg <= STEP_W'(NSTEPS)), "CORDIC step count overran")
    `PFT_ASSERT_NEXT(a_stall_keeps_stage3, v3_reg && v4_reg && !m_tready, v3_reg, "stage 3 request lost on stall")
    `PFT_ASSERT(a_cos_range, (cos_reg <= 18'sd65536) && (cos_reg >= -18'sd65536), "cosine out of range")
    `PFT_ASSERT(a_sin_range, (sin_reg <= 18'sd65536) && (sin_reg >= -18'sd65536), "sine out of range")

endmodule

// ===== tb/tb_pose_frame_transform.sv =====
module tb_pose_frame_transform;
    import pft_pkg::*;

    localparam int CORDIC_STEPS  = 16;
    localparam int SETTLE_CYCLES = 32;     // covers pipeline depth and a full CORDIC pass
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AT       = 300;    // results seen before the long receiver hold
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_POSES   = 100;

    localparam reg_index_t  REG_UNUSED = 2'd3;
    localparam logic [31:0] S32_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN    = 32'h8000_0000;

    typedef enum logic [1:0] {PLAN_POSE, PLAN_REG, PLAN_PAUSE} plan_kind_t;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} ready_mode_t;

    typedef struct packed {
        logic               act;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
    } pose_req_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [16:0] heading;
    } pose_res_t;

    typedef struct {
        plan_kind_t  kind;
        pose_req_t   pose;
        reg_index_t  idx;
        logic [31:0] data;
    } plan_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;      // in_x[31:0], in_y[63:32], in_heading[79:64]
    logic        s_tuser = 1'b0;    // action[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;           // out_x[31:0], out_y[63:32], out_heading[80:64], zero

    pose_frame_transform uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    plan_entry_t request_plan[$];
    pose_res_t   poses_due[$];

    // shadow of the frame configuration
    longint ctr_x, ctr_y, frame_ang, rot_cos, rot_sin;

    int     failures = 0;
    int     poses_accepted = 0;
    int     results_seen = 0;
    int     settings_used = 0;
    longint cycles = 0;
    logic   req_taken = 1'b0;

    // Q2.30 to Q1.16, round half up, clamp to +-1.0
    function automatic longint q30_to_q16(longint v);
        longint r;
        r = (v + 64'sd8192) >>> 14;
        if (r > 64'sd65536)
            r = 64'sd65536;
        else if (r < -64'sd65536)
            r = -64'sd65536;
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_s32(longint v);
        if (v > 64'sd2147483647)
            return S32_MAX;
        if (v < -64'sd2147483648)
            return S32_MIN;
        return v[31:0];
    endfunction

    // expected result of one pose under the current frame
    function automatic pose_res_t transform_pose(pose_req_t p);
        longint    dx, dy, ox, oy, hsum, hmod;
        pose_res_t res;
        if (p.act == ACT_TO_LOCAL)
        begin
            dx   = longint'(p.x) - ctr_x;
            dy   = longint'(p.y) - ctr_y;
            ox   = (dx * rot_cos + dy * rot_sin + 64'sd32768) >>> 16;
            oy   = (dy * rot_cos - dx * rot_sin + 64'sd32768) >>> 16;
            hsum = longint'(p.heading) - frame_ang;
        end
        else
        begin
            ox   = ((longint'(p.x) * rot_cos - longint'(p.y) * rot_sin + 64'sd32768) >>> 16)
                   + ctr_x;
            oy   = ((longint'(p.x) * rot_sin + longint'(p.y) * rot_cos + 64'sd32768) >>> 16)
                   + ctr_y;
            hsum = longint'(p.heading) + frame_ang;
        end
        // wrap to (-half turn, +half turn]
        hmod = hsum & 64'sd65535;
        if (hmod > 64'sd32768)
            hmod = hmod - 64'sd65536;
        res.x       = clamp_s32(ox);
        res.y       = clamp_s32(oy);
        res.heading = hmod[16:0];
        return res;
    endfunction

    // Coordinate: mostly full range, with extremes and small values mixed in
    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return {{12{r[31]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_pose(logic act, logic [31:0] x, logic [31:0] y, logic [15:0] h);
        plan_entry_t e;
        e.kind = PLAN_POSE;
        e.pose = '{act: act, x: x, y: y, heading: h};
        e.idx  = REG_UNUSED;
        e.data = '0;
        request_plan.push_back(e);
    endtask

    task automatic add_reg(reg_index_t idx, logic [31:0] data);
        plan_entry_t e;
        e.kind = PLAN_REG;
        e.pose = '0;
        e.idx  = idx;
        e.data = data;
        request_plan.push_back(e);
    endtask

    // drain, then a new frame; the angle goes last so the CORDIC runs on an idle block
    task automatic add_frame(logic [31:0] cx, logic [31:0] cy, logic [31:0] ang);
        plan_entry_t e;
        e.kind = PLAN_PAUSE;
        e.pose = '0;
        e.idx  = REG_UNUSED;
        e.data = '0;
        request_plan.push_back(e);
        add_reg(REG_CENTER_X, cx);
        add_reg(REG_CENTER_Y, cy);
        add_reg(REG_UNUSED, $urandom());
        add_reg(REG_FRAME_ANGLE, ang);
        settings_used++;
    endtask

    // Frame shadow: follows register writes, cosine and sine from a CORDIC
    always @(posedge clk or negedge rst_n)
    begin
        longint z, cx, sy, xs, ys;
        logic   neg;
        if (!rst_n)
        begin
            ctr_x     <= 0;
            ctr_y     <= 0;
            frame_ang <= 0;
            rot_cos   <= 64'sd65536;
            rot_sin   <= 0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CENTER_X: ctr_x <= longint'($signed(cfg_data));
                REG_CENTER_Y: ctr_y <= longint'($signed(cfg_data));
                REG_FRAME_ANGLE:
                begin
                    z   = longint'($signed({cfg_data[15:0], 16'h0000}));
                    neg = 1'b0;
                    // fold into [-quarter, +quarter] turn
                    if (z > 64'sd1073741824)
                    begin
                        z   = z - 64'sd2147483648;
                        neg = 1'b1;
                    end
                    else if (z < -64'sd1073741824)
                    begin
                        z   = z + 64'sd2147483648;
                        neg = 1'b1;
                    end
                    cx = longint'(Q30_INV_GAIN);
                    sy = 0;
                    for (int i = 0; i < CORDIC_STEPS; i++)
                    begin
                        xs = cx >>> i;
                        ys = sy >>> i;
                        if (z >= 0)
                        begin
                            cx = cx - ys;
                            sy = sy + xs;
                            z  = z - longint'(ATAN_TURN32[i]);
                        end
                        else
                        begin
                            cx = cx + ys;
                            sy = sy - xs;
                            z  = z + longint'(ATAN_TURN32[i]);
                        end
                    end
                    if (neg)
                    begin
                        cx = -cx;
                        sy = -sy;
                    end
                    frame_ang <= longint'($signed(cfg_data[15:0]));
                    rot_cos   <= q30_to_q16(cx);
                    rot_sin   <= q30_to_q16(sy);
                end
                default: ;
            endcase
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        pose_res_t want;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                poses_due.push_back(transform_pose(pose_req_t'({s_tuser, s_tdata[31:0],
                                                                s_tdata[63:32], s_tdata[79:64]})));
                poses_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (poses_due.size() == 0)
                begin
                    $error("result with no request outstanding: tdata %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = poses_due.pop_front();
                    if (m_tdata[31:0] !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, $signed(m_tdata[31:0]));
                        failures++;
                    end
                    if (m_tdata[63:32] !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, $signed(m_tdata[63:32]));
                        failures++;
                    end
                    if (m_tdata[80:64] !== want.heading)
                    begin
                        $error("out_heading: expected %0d, got %0d",
                               want.heading, $signed(m_tdata[80:64]));
                        failures++;
                    end
                    if (m_tdata[87:81] !== 7'd0)
                    begin
                        $error("tdata padding: expected 0, got %h", m_tdata[87:81]);
                        failures++;
                    end
                end
            end
        end
    end

    // Driver: bursts of requests with random gaps, register writes, pauses
    int burst_left = 0;
    int gap_left = 0;
    int settle = 0;

    always @(negedge clk)
    begin
        logic        vld;
        logic        wr;
        plan_entry_t head;
        vld = s_tvalid && !req_taken;
        wr  = 1'b0;
        if (rst_n && !vld)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (request_plan.size() > 0)
            begin
                head = request_plan[0];
                case (head.kind)
                    PLAN_POSE:
                    begin
                        void'(request_plan.pop_front());
                        s_tdata <= {head.pose.heading, head.pose.y, head.pose.x};
                        s_tuser <= head.pose.act;
                        vld = 1'b1;
                        if (burst_left > 0)
                            burst_left--;
                        else
                        begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                        end
                    end
                    PLAN_REG:
                    begin
                        void'(request_plan.pop_front());
                        cfg_index <= head.idx;
                        cfg_data  <= head.data;
                        wr = 1'b1;
                    end
                    default:
                    begin
                        // wait for every result, then let the block go quiet
                        settle = (poses_due.size() == 0) ? settle + 1 : 0;
                        if (settle >= SETTLE_CYCLES)
                        begin
                            void'(request_plan.pop_front());
                            settle = 0;
                        end
                    end
                endcase
            end
        end
        s_tvalid  <= vld;
        cfg_write <= wr;
    end

    // Receiver: changing ready patterns plus one long hold
    ready_mode_t rdy_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int          hold_left = 0;
    logic        held_once = 1'b0;

    always @(negedge clk)
    begin
        logic rdy;
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (!held_once && results_seen >= HOLD_AT)
        begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rdy_mode  = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (rdy_mode)
                RDY_ALWAYS: rdy = 1'b1;
                RDY_RANDOM: rdy = 1'($urandom_range(0, 1));
                default:    rdy = (mode_left % 3) != 0;
            endcase
        end
        m_tready <= rdy;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, poses_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus plan and end of run
    initial
    begin
        // reset frame: identity rotation, heading wrap at the half turn
        add_pose(ACT_TO_LOCAL, 32'h0, 32'h0, 16'h0000);
        add_pose(ACT_TO_LOCAL, S32_MAX, S32_MIN, 16'h8000);
        add_pose(ACT_TO_WORLD, S32_MIN, S32_MAX, 16'h7FFF);
        add_pose(ACT_TO_WORLD, 32'h0001_8000, 32'hFFFF_7FFF, 16'h8000);
        add_pose(ACT_TO_LOCAL, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0001);

        // extreme centers, frame at minus pi: saturation both ways
        add_frame(S32_MAX, S32_MIN, 32'hFFFF_8000);
        add_pose(ACT_TO_LOCAL, S32_MIN, S32_MAX, 16'h0000);
        add_pose(ACT_TO_LOCAL, S32_MAX, S32_MIN, 16'h8000);
        add_pose(ACT_TO_WORLD, S32_MAX, S32_MAX, 16'h7FFF);
        add_pose(ACT_TO_WORLD, S32_MIN, S32_MIN, 16'h8000);
        add_pose(ACT_TO_LOCAL, 32'h0, 32'h0, 16'h4000);

        add_frame(S32_MIN, S32_MAX, 32'h0000_7FFF);
        add_pose(ACT_TO_LOCAL, S32_MAX, S32_MIN, 16'h8001);
        add_pose(ACT_TO_WORLD, S32_MIN, S32_MAX, 16'h7FFF);
        add_pose(ACT_TO_WORLD, S32_MAX, S32_MIN, 16'h0001);
        add_pose(ACT_TO_LOCAL, 32'h0000_1000, 32'hFFFF_F000, 16'hFFFF);

        // quarter turns
        add_frame(32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000);
        add_pose(ACT_TO_LOCAL, 32'h0003_0000, 32'h0002_0000, 16'h0000);
        add_pose(ACT_TO_WORLD, S32_MAX, 32'h0, 16'h4000);
        add_pose(ACT_TO_LOCAL, S32_MIN, S32_MIN, 16'hC000);

        add_frame(32'h0, 32'h0, 32'hABCD_C000);
        add_pose(ACT_TO_WORLD, 32'h0, S32_MAX, 16'h8000);
        add_pose(ACT_TO_LOCAL, S32_MAX, 32'h0, 16'h3FFF);
        add_pose(ACT_TO_WORLD, 32'h0000_8000, 32'h0000_8000, 16'h7FFF);

        // random frames with random poses
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            add_frame(pick_coord(), pick_coord(), {16'($urandom()), pick_angle()});
            for (int k = 0; k < PHASE_POSES; k++)
                add_pose(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_angle());
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_plan.size() > 0 || s_tvalid || poses_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d pose requests in both directions over %0d frame settings",
                 results_seen, poses_accepted, settings_used + 1);
        $display("Included saturated positions, half-turn headings and a long output hold");
        if (failures == 0 && poses_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
